// File: design/srt_pkg.sv
// Package for the sorted record table: field widths, record layout, codes,
// and the command and status bundles between controller and datapath.
// No dependencies.
package srt_pkg;

    // Default table depth and the fixed widths of the item and result fields.
    localparam int SRT_DEPTH = 16;
    localparam int KIND_W    = 2;
    localparam int KEY_W     = 16;
    localparam int SCORE_W   = 10;
    localparam int NAME_W    = 64;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 5;

    // Command kinds carried by an input item.
    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_QUERY  = 2'd2,
        KIND_CLEAR  = 2'd3
    } t_kind;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    // One stored record.
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [SCORE_W-1:0] score;
        logic [NAME_W-1:0]  name;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    // Read address source for the record memory.
    typedef enum logic [2:0] {
        RA_HOLD = 3'd0,
        RA_ZERO = 3'd1,
        RA_TOP  = 3'd2,
        RA_DEC  = 3'd3,
        RA_INC  = 3'd4
    } t_ra_sel;

    // Write address relative to the walk index.
    typedef enum logic [1:0] {
        WA_AT    = 2'd0,
        WA_ABOVE = 2'd1,
        WA_BELOW = 2'd2
    } t_wa_sel;

    // Fill count update.
    typedef enum logic [1:0] {
        CNT_HOLD = 2'd0,
        CNT_INC  = 2'd1,
        CNT_DEC  = 2'd2,
        CNT_CLR  = 2'd3
    } t_cnt_op;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    ld_item;
        t_ra_sel ra_sel;
        logic    step;
        logic    wr_en;
        t_wa_sel wa_sel;
        logic    wd_new;
        logic    rec_ld;
        t_cnt_op cnt_op;
        logic    res_ld;
        t_status res_status;
        logic    res_show;
        logic    out_ld;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cnt_zero;
        logic cnt_full;
        logic idx_zero;
        logic idx_last;
        logic key_gt;
        logic key_eq;
        logic score_gt;
    } t_stat;

endpackage

// File: design/srt_ram.sv
// Generic single-write, single-read memory with a registered read port.
// Defaults come from srt_pkg.
module srt_ram #(
    parameter int WIDTH = srt_pkg::REC_W,
    parameter int DEPTH = srt_pkg::SRT_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/srt_datapath.sv
// Datapath of the sorted record table: record memory, walk index, fill
// count, working record and result registers. Uses srt_pkg and srt_ram.
module srt_datapath #(
    parameter int DEPTH = srt_pkg::SRT_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  srt_pkg::t_cmd                 i_cmd,
    output srt_pkg::t_stat                o_stat,
    input  logic [srt_pkg::KEY_W-1:0]     i_key,
    input  logic [srt_pkg::SCORE_W-1:0]   i_score,
    input  logic [srt_pkg::NAME_W-1:0]    i_name_tag,
    output logic [srt_pkg::STATUS_W-1:0]  o_status,
    output logic [srt_pkg::KEY_W-1:0]     o_key_out,
    output logic [srt_pkg::SCORE_W-1:0]   o_score_out,
    output logic [srt_pkg::NAME_W-1:0]    o_name_out,
    output logic [srt_pkg::COUNT_W-1:0]   o_entry_count
);
    import srt_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_rec            r_item;
    t_rec            r_rec;
    t_rec            r_out_rec;
    logic [AW-1:0]   r_idx;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    t_status         r_res_status;
    logic            r_res_show;
    t_status         r_out_status;
    logic [COUNT_W-1:0] r_out_count;

    t_rec            w_rdata;
    t_rec            w_wdata;
    logic [AW-1:0]   w_raddr;
    logic [AW:0]     w_wa_wide;
    logic [CW-1:0]   w_last;

    // Index of the highest occupied entry.
    assign w_last = r_count - CW'(1);

    // Read address selection.
    always_comb begin
        unique case (i_cmd.ra_sel)
            RA_HOLD: w_raddr = r_idx;
            RA_ZERO: w_raddr = '0;
            RA_TOP:  w_raddr = w_last[AW-1:0];
            RA_DEC:  w_raddr = r_idx - AW'(1);
            RA_INC:  w_raddr = r_idx + AW'(1);
            default: w_raddr = r_idx;
        endcase
    end

    // Write address relative to the walk index, and write data.
    always_comb begin
        unique case (i_cmd.wa_sel)
            WA_AT:    w_wa_wide = {1'b0, r_idx};
            WA_ABOVE: w_wa_wide = {1'b0, r_idx} + (AW + 1)'(1);
            WA_BELOW: w_wa_wide = {1'b0, r_idx} - (AW + 1)'(1);
            default:  w_wa_wide = {1'b0, r_idx};
        endcase
    end

    assign w_wdata = i_cmd.wd_new ? r_item : w_rdata;

    srt_ram #(
        .WIDTH (REC_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (w_wa_wide[AW-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Status for the controller.
    always_comb begin
        o_stat.cnt_zero = (r_count == '0);
        o_stat.cnt_full = (r_count == CW'(DEPTH));
        o_stat.idx_zero = (r_idx == '0);
        o_stat.idx_last = (CW'(r_idx) == w_last);
        o_stat.key_gt   = (w_rdata.key > r_item.key);
        o_stat.key_eq   = (w_rdata.key == r_item.key);
        o_stat.score_gt = (w_rdata.score > r_rec.score);
    end

    // Next fill count.
    always_comb begin
        case (i_cmd.cnt_op)
            CNT_INC: n_count = r_count + CW'(1);
            CNT_DEC: n_count = r_count - CW'(1);
            CNT_CLR: n_count = '0;
            default: n_count = r_count;
        endcase
    end

    // Fill count is control state and is cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Item, walk index, working record and result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_item) begin
            r_item <= {i_key, i_score, i_name_tag};
        end
        if (i_cmd.step) begin
            r_idx <= w_raddr;
        end
        if (i_cmd.rec_ld) begin
            r_rec <= w_rdata;
        end
        if (i_cmd.res_ld) begin
            r_res_status <= i_cmd.res_status;
            r_res_show   <= i_cmd.res_show;
        end
        if (i_cmd.out_ld) begin
            r_out_status <= r_res_status;
            r_out_rec    <= r_res_show ? r_rec : '0;
            r_out_count  <= COUNT_W'(r_count);
        end
    end

    assign o_status      = r_out_status;
    assign o_key_out     = r_out_rec.key;
    assign o_score_out   = r_out_rec.score;
    assign o_name_out    = r_out_rec.name;
    assign o_entry_count = r_out_count;

`ifndef NO_ASSERTIONS
    // The fill count never passes the table depth.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count beyond table depth");

    // Every write lands inside the table.
    a_write_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_en |-> (w_wa_wide < (AW + 1)'(DEPTH)))
        else $error("record write outside the table");

    // A record is only taken from an occupied entry.
    a_read_occupied: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rec_ld |-> (CW'(r_idx) < r_count))
        else $error("record taken from an empty entry");
`endif

endmodule

// File: design/srt_ctrl.sv
// Controller of the sorted record table: sequences the memory walks for
// insert, delete and query, and owns both handshakes. Uses srt_pkg.
module srt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  srt_pkg::t_kind  i_kind,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  srt_pkg::t_stat  i_stat,
    output srt_pkg::t_cmd   o_cmd
);
    import srt_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_INS_CHK = 7'b0000010,
        S_INS_PUT = 7'b0000100,
        S_DEL_CHK = 7'b0001000,
        S_DEL_SHF = 7'b0010000,
        S_QRY_CHK = 7'b0100000,
        S_FIN     = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.ld_item = 1'b1;
                    unique case (i_kind) inside
                        KIND_INSERT: begin
                            if (i_stat.cnt_full) begin
                                o_cmd.res_ld     = 1'b1;
                                o_cmd.res_status = ST_FULL;
                                n_state          = S_FIN;
                            end else if (i_stat.cnt_zero) begin
                                o_cmd.ra_sel = RA_ZERO;
                                o_cmd.step   = 1'b1;
                                n_state      = S_INS_PUT;
                            end else begin
                                o_cmd.ra_sel = RA_TOP;
                                o_cmd.step   = 1'b1;
                                n_state      = S_INS_CHK;
                            end
                        end
                        KIND_DELETE, KIND_QUERY: begin
                            if (i_stat.cnt_zero) begin
                                o_cmd.res_ld     = 1'b1;
                                o_cmd.res_status = ST_EMPTY;
                                n_state          = S_FIN;
                            end else begin
                                o_cmd.ra_sel = RA_ZERO;
                                o_cmd.step   = 1'b1;
                                n_state      = (i_kind == KIND_DELETE) ? S_DEL_CHK
                                                                       : S_QRY_CHK;
                            end
                        end
                        default: begin
                            o_cmd.cnt_op     = CNT_CLR;
                            o_cmd.res_ld     = 1'b1;
                            o_cmd.res_status = ST_OK;
                            n_state          = S_FIN;
                        end
                    endcase
                end
            end
            // Walk down from the top, moving larger keys up one place.
            S_INS_CHK: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wa_sel = WA_ABOVE;
                if (i_stat.key_gt) begin
                    if (i_stat.idx_zero) begin
                        n_state = S_INS_PUT;
                    end else begin
                        o_cmd.ra_sel = RA_DEC;
                        o_cmd.step   = 1'b1;
                    end
                end else begin
                    o_cmd.wd_new     = 1'b1;
                    o_cmd.cnt_op     = CNT_INC;
                    o_cmd.res_ld     = 1'b1;
                    o_cmd.res_status = ST_OK;
                    n_state          = S_FIN;
                end
            end
            // New record goes at the walk index itself.
            S_INS_PUT: begin
                o_cmd.wr_en      = 1'b1;
                o_cmd.wa_sel     = WA_AT;
                o_cmd.wd_new     = 1'b1;
                o_cmd.cnt_op     = CNT_INC;
                o_cmd.res_ld     = 1'b1;
                o_cmd.res_status = ST_OK;
                n_state          = S_FIN;
            end
            // Search upwards for the first matching key.
            S_DEL_CHK: begin
                if (i_stat.key_eq) begin
                    o_cmd.rec_ld = 1'b1;
                    if (i_stat.idx_last) begin
                        o_cmd.cnt_op     = CNT_DEC;
                        o_cmd.res_ld     = 1'b1;
                        o_cmd.res_status = ST_OK;
                        o_cmd.res_show   = 1'b1;
                        n_state          = S_FIN;
                    end else begin
                        o_cmd.ra_sel = RA_INC;
                        o_cmd.step   = 1'b1;
                        n_state      = S_DEL_SHF;
                    end
                end else if (i_stat.idx_last) begin
                    o_cmd.res_ld     = 1'b1;
                    o_cmd.res_status = ST_MISSING;
                    n_state          = S_FIN;
                end else begin
                    o_cmd.ra_sel = RA_INC;
                    o_cmd.step   = 1'b1;
                end
            end
            // Close the gap by moving each later record down one place.
            S_DEL_SHF: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wa_sel = WA_BELOW;
                if (i_stat.idx_last) begin
                    o_cmd.cnt_op     = CNT_DEC;
                    o_cmd.res_ld     = 1'b1;
                    o_cmd.res_status = ST_OK;
                    o_cmd.res_show   = 1'b1;
                    n_state          = S_FIN;
                end else begin
                    o_cmd.ra_sel = RA_INC;
                    o_cmd.step   = 1'b1;
                end
            end
            // Keep the first record with the highest score.
            S_QRY_CHK: begin
                o_cmd.rec_ld = i_stat.idx_zero || i_stat.score_gt;
                if (i_stat.idx_last) begin
                    o_cmd.res_ld     = 1'b1;
                    o_cmd.res_status = ST_OK;
                    o_cmd.res_show   = 1'b1;
                    n_state          = S_FIN;
                end else begin
                    o_cmd.ra_sel = RA_INC;
                    o_cmd.step   = 1'b1;
                end
            end
            // Hand the result over once the output register is free.
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_ld = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output valid follows the result register.
    always_comb begin
        if (o_cmd.out_ld) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef NO_ASSERTIONS
    // A result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_ld |-> (!r_out_valid || i_out_ready))
        else $error("pending result overwritten");

    // Only one item is at work at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second item taken while one is at work");

    // An insert never grows a full table.
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.cnt_op == CNT_INC) |-> !i_stat.cnt_full)
        else $error("insert into a full table");
`endif

endmodule

// File: design/sorted_record_table.sv
// Sorted record table: holds up to DEPTH records (key, score, name tag) in
// ascending key order in a single record memory with one write and one
// registered read port, and serves one command item at a time. An item is
// taken when the block is idle; the work then walks the memory one record
// per cycle (clear and a full or empty answer need no walk), after which
// the result goes to the output register. A new item may be taken while
// that result still waits on the output side. The memory is not cleared
// at reset: only entries below the fill count are ever read.
module sorted_record_table #(
    parameter int DEPTH = srt_pkg::SRT_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [srt_pkg::KIND_W-1:0]    i_kind,
    input  logic [srt_pkg::KEY_W-1:0]     i_key,
    input  logic [srt_pkg::SCORE_W-1:0]   i_score,
    input  logic [srt_pkg::NAME_W-1:0]    i_name_tag,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [srt_pkg::STATUS_W-1:0]  o_status,
    output logic [srt_pkg::KEY_W-1:0]     o_key_out,
    output logic [srt_pkg::SCORE_W-1:0]   o_score_out,
    output logic [srt_pkg::NAME_W-1:0]    o_name_out,
    output logic [srt_pkg::COUNT_W-1:0]   o_entry_count
);
    import srt_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // Sequencing of the walks and the two handshakes.
    srt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (t_kind'(i_kind)),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // Record memory, counters and result registers.
    srt_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_key         (i_key),
        .i_score       (i_score),
        .i_name_tag    (i_name_tag),
        .o_status      (o_status),
        .o_key_out     (o_key_out),
        .o_score_out   (o_score_out),
        .o_name_out    (o_name_out),
        .o_entry_count (o_entry_count)
    );

endmodule
